// File: src/dlcs_pkg.sv
// Package for the delimited line cell splitter.
// Holds the command word passed from the front to the back, the codes and the sizes.
// No dependencies.
package dlcs_pkg;

   localparam int HELD_SPACE_DEPTH_DEF = 16;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB = 8'h09;
   localparam logic [7:0] DELIM_RESET = 8'd44;

   localparam logic [1:0] QM_OUTSIDE = 2'd0;
   localparam logic [1:0] QM_INSIDE = 2'd1;
   localparam logic [1:0] QM_PENDING = 2'd2;

   localparam logic ACT_BYTE = 1'b0;
   localparam logic ACT_EOL = 1'b1;

   localparam logic [1:0] KIND_BYTE = 2'd0;
   localparam logic [1:0] KIND_CELL_END = 2'd1;
   localparam logic [1:0] KIND_LINE_END = 2'd2;

   localparam logic [1:0] OP_HOLD = 2'd0;
   localparam logic [1:0] OP_CONTENT = 2'd1;
   localparam logic [1:0] OP_END_CELL = 2'd2;
   localparam logic [1:0] OP_END_LINE = 2'd3;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] data;
      logic       trunc;
   } dlcs_cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } dlcs_queue_status_type;

   function automatic logic is_ws(input logic [7:0] b);
      is_ws = (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
   endfunction

endpackage

// File: src/dlcs_front.sv
// Front end of the splitter: accepts words, tracks quoting and cell state,
// and issues hold, content and end commands. Depends on dlcs_pkg.
module dlcs_front
   import dlcs_pkg::*;
#(
   parameter int HELD_SPACE_DEPTH = HELD_SPACE_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  item_valid,
   input  logic                  item_action,
   input  logic [7:0]            item_byte,
   input  logic                  delim_wr,
   input  logic [7:0]            delim_data,
   input  dlcs_queue_status_type q_status,
   output logic                  item_ready,
   output logic                  cmd_push,
   output dlcs_cmd_type          cmd
);

   localparam int CNT_W = $clog2(HELD_SPACE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(HELD_SPACE_DEPTH);

   logic [7:0]       delim_ff, delim_in;
   logic [1:0]       quote_ff, quote_in;
   logic             started_ff, started_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             ovf_ff, ovf_in;

   logic             accept;
   logic [1:0]       q_eff;
   logic             do_content;
   logic [7:0]       content_b;
   logic             do_end;

   assign item_ready = !q_status.full;
   assign accept = item_valid && item_ready;
   assign delim_in = delim_wr ? delim_data : delim_ff;

   always_comb begin
      quote_in = quote_ff;
      started_in = started_ff;
      count_in = count_ff;
      ovf_in = ovf_ff;
      cmd_push = 1'b0;
      cmd = '{op: OP_HOLD, data: item_byte, trunc: 1'b0};
      do_content = 1'b0;
      do_end = 1'b0;
      content_b = item_byte;
      q_eff = (quote_ff == QM_OUTSIDE || quote_ff == QM_INSIDE) ? quote_ff : QM_OUTSIDE;
      if (accept) begin
         if (item_action == ACT_EOL) begin
            do_end = 1'b1;
            cmd.op = OP_END_LINE;
            quote_in = QM_OUTSIDE;
         end else if (quote_ff == QM_PENDING && item_byte == CH_QUOTE) begin
            quote_in = QM_INSIDE;
            do_content = 1'b1;
            content_b = CH_QUOTE;
         end else begin
            quote_in = q_eff;
            priority if (item_byte == CH_CR) begin
               quote_in = q_eff;
            end else if (item_byte == CH_QUOTE) begin
               quote_in = (q_eff == QM_INSIDE) ? QM_PENDING : QM_INSIDE;
            end else if (item_byte == delim_ff && q_eff == QM_OUTSIDE) begin
               do_end = 1'b1;
               cmd.op = OP_END_CELL;
            end else begin
               do_content = 1'b1;
            end
         end
         if (do_end) begin
            cmd_push = 1'b1;
            cmd.trunc = ovf_ff;
            started_in = 1'b0;
            count_in = '0;
            ovf_in = 1'b0;
         end
         if (do_content) begin
            cmd.data = content_b;
            if (is_ws(content_b)) begin
               if (started_ff) begin
                  if (count_ff < DEPTH_C) begin
                     cmd_push = 1'b1;
                     cmd.op = OP_HOLD;
                     count_in = count_ff + 1'b1;
                  end else begin
                     ovf_in = 1'b1;
                  end
               end
            end else begin
               cmd_push = 1'b1;
               cmd.op = OP_CONTENT;
               count_in = '0;
               started_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delim_ff <= DELIM_RESET;
         quote_ff <= QM_OUTSIDE;
         started_ff <= 1'b0;
         count_ff <= '0;
         ovf_ff <= 1'b0;
      end else begin
         delim_ff <= delim_in;
         quote_ff <= quote_in;
         started_ff <= started_in;
         count_ff <= count_in;
         ovf_ff <= ovf_in;
      end
   end

endmodule

// File: src/dlcs_queue.sv
// Short command queue between the front and the back of the splitter.
// Depends on dlcs_pkg.
module dlcs_queue
   import dlcs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  dlcs_cmd_type          push_cmd,
   input  logic                  pop,
   output dlcs_cmd_type          head,
   output dlcs_queue_status_type status
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

   dlcs_cmd_type     slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   assign status.full = (cnt_ff == DEPTH_C);
   assign status.empty = (cnt_ff == '0);
   assign head = slot_ff[rd_ff];

   always_comb begin
      wr_in = push ? wr_ff + 1'b1 : wr_ff;
      rd_in = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_cmd;
      end
   end

endmodule

// File: src/dlcs_back.sv
// Back end of the splitter: keeps held whitespace, releases it before content,
// and drives the registered result stage. Depends on dlcs_pkg.
module dlcs_back
   import dlcs_pkg::*;
#(
   parameter int HELD_SPACE_DEPTH = HELD_SPACE_DEPTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         q_empty,
   input  dlcs_cmd_type head,
   output logic         pop,
   input  logic         out_ready,
   output logic         out_valid,
   output logic [1:0]   out_kind,
   output logic [7:0]   out_byte,
   output logic         out_trunc,
   output logic         out_last
);

   localparam int CNT_W = $clog2(HELD_SPACE_DEPTH + 1);
   localparam int IDX_W = (HELD_SPACE_DEPTH > 1) ? $clog2(HELD_SPACE_DEPTH) : 1;

   logic [7:0]       held_mem [HELD_SPACE_DEPTH];
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] rel_ff, rel_in;
   logic             valid_ff, valid_in;
   logic [1:0]       kind_ff, kind_in;
   logic [7:0]       byte_ff, byte_in;
   logic             trunc_ff, trunc_in;
   logic             last_ff, last_in;
   logic             slot_free;
   logic             hold_wr;
   logic             rel_rd;

   assign slot_free = !valid_ff || out_ready;

   always_comb begin
      count_in = count_ff;
      rel_in = rel_ff;
      valid_in = valid_ff && !out_ready;
      kind_in = kind_ff;
      byte_in = byte_ff;
      trunc_in = trunc_ff;
      last_in = last_ff;
      pop = 1'b0;
      hold_wr = 1'b0;
      rel_rd = 1'b0;
      if (!q_empty) begin
         unique case (head.op)
            OP_HOLD: begin
               hold_wr = 1'b1;
               count_in = count_ff + 1'b1;
               pop = 1'b1;
            end
            OP_CONTENT: begin
               if (slot_free) begin
                  valid_in = 1'b1;
                  kind_in = KIND_BYTE;
                  trunc_in = 1'b0;
                  if (rel_ff < count_ff) begin
                     rel_rd = 1'b1;
                     last_in = 1'b0;
                     rel_in = rel_ff + 1'b1;
                  end else begin
                     byte_in = head.data;
                     last_in = 1'b1;
                     rel_in = '0;
                     count_in = '0;
                     pop = 1'b1;
                  end
               end
            end
            OP_END_CELL, OP_END_LINE: begin
               if (slot_free) begin
                  valid_in = 1'b1;
                  kind_in = (head.op == OP_END_LINE) ? KIND_LINE_END : KIND_CELL_END;
                  byte_in = 8'd0;
                  trunc_in = head.trunc;
                  last_in = 1'b1;
                  rel_in = '0;
                  count_in = '0;
                  pop = 1'b1;
               end
            end
            default: begin
               pop = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         rel_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         rel_ff <= rel_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      trunc_ff <= trunc_in;
      last_ff <= last_in;
      if (rel_rd) begin
         byte_ff <= held_mem[rel_ff[IDX_W-1:0]];
      end else begin
         byte_ff <= byte_in;
      end
   end

   always_ff @(posedge clock) begin
      if (hold_wr) begin
         held_mem[count_ff[IDX_W-1:0]] <= head.data;
      end
   end

   assign out_valid = valid_ff;
   assign out_kind = kind_ff;
   assign out_byte = byte_ff;
   assign out_trunc = trunc_ff;
   assign out_last = last_ff;

endmodule

// File: src/delimited_line_cell_splitter.sv
// With the queue empty, an accepted word passes through the queue slot and then the registered
// result stage before its first result reaches rsp. Throughput: one input word per cycle into a
// four-entry queue while the queue is not full; the back end takes one command at a time and
// releases each held whitespace byte on rsp before the content byte. Depends on dlcs_pkg.
// Reset (synchronous) empties the queue and result stage, clears the cell state and
// sets the delimiter to a comma.
module delimited_line_cell_splitter
   import dlcs_pkg::*;
#(
   parameter int HELD_SPACE_DEPTH = HELD_SPACE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // line_byte[7:0]
   input  logic        req_tuser,   // action[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // cell_byte[7:0], cell_truncated[8], zero[15:9]
   output logic [1:0]  rsp_tuser,   // result_kind[1:0]
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data
);

   dlcs_queue_status_type q_status;
   dlcs_cmd_type          push_cmd;
   dlcs_cmd_type          head;
   logic                  push;
   logic                  pop;
   logic [7:0]            cell_byte;
   logic                  cell_trunc;

   assign csr_ready = 1'b1;

   dlcs_front #(
      .HELD_SPACE_DEPTH(HELD_SPACE_DEPTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (req_tvalid),
      .item_action (req_tuser),
      .item_byte   (req_tdata),
      .delim_wr    (csr_valid),
      .delim_data  (csr_data),
      .q_status    (q_status),
      .item_ready  (req_tready),
      .cmd_push    (push),
      .cmd         (push_cmd)
   );

   dlcs_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (head),
      .status   (q_status)
   );

   dlcs_back #(
      .HELD_SPACE_DEPTH(HELD_SPACE_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_status.empty),
      .head      (head),
      .pop       (pop),
      .out_ready (rsp_tready),
      .out_valid (rsp_tvalid),
      .out_kind  (rsp_tuser),
      .out_byte  (cell_byte),
      .out_trunc (cell_trunc),
      .out_last  (rsp_tlast)
   );

   assign rsp_tdata = {7'd0, cell_trunc, cell_byte};

endmodule
